FILE: rtl/pidaw_pkg.sv
package pidaw_pkg;

	// Axis count and select width
	localparam int unsigned AXES   = 4;
	localparam int unsigned AXIS_W = $clog2(AXES);

	// Integral accumulator width (signed, Q.20)
	localparam int unsigned INT_W = 40;

	// Sample and gain widths
	localparam int unsigned DATA_W = 16;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned ERR_W  = DATA_W + 1;
	localparam int unsigned PROD_W = GAIN_W + ERR_W;

	// Configuration port
	localparam int unsigned NUM_REGS = 4;
	localparam int unsigned CFG_W    = 3 * GAIN_W;
	localparam int unsigned CFG_IW   = $clog2(NUM_REGS);

	localparam logic [CFG_IW-1:0] REG_GAINS_THRUST = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_GAINS_ROLL   = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_GAINS_PITCH  = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_GAINS_YAW    = CFG_IW'(3);

	// Effort scaling and output clamp (+-1.0 in Q2.14)
	localparam int unsigned EFFORT_SHIFT = 6;
	localparam int          DRIVE_LIMIT  = 16384;

	// Packed gain register
	typedef struct packed {
		logic signed [GAIN_W-1:0] kd;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kp;
	} gains_t;

endpackage

FILE: rtl/pid_axis_antiwindup_top.sv
// PID controller with conditional-integration anti-windup, one tick per request for one of
// four axes. Takes one request per clock while the result register is free or being taken.
// A request's result passes through the input register, which loads at acceptance, then the
// product register, then the result register. The per-axis integrals live in a small
// synchronous RAM with one read and one write each cycle the pipeline moves. A request that
// follows one for the same axis gets the freshly written integral through a forwarding path,
// so back-to-back requests on one axis run at full rate. Gain registers may only be written
// while the pipeline is empty. With enable low the manual drive passes through and the axis
// integral is reloaded with Ki*error.
module pid_axis_antiwindup_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [pidaw_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [pidaw_pkg::CFG_W-1:0]         cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pidaw_pkg::AXIS_W-1:0]        axis,
	input  logic signed [pidaw_pkg::DATA_W-1:0] setpoint,
	input  logic signed [pidaw_pkg::DATA_W-1:0] measured,
	input  logic signed [pidaw_pkg::DATA_W-1:0] rate,
	input  logic signed [pidaw_pkg::DATA_W-1:0] manual_drive,
	input  logic                                enable,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pidaw_pkg::AXIS_W-1:0]        axis_out,
	output logic signed [pidaw_pkg::DATA_W-1:0] drive,
	output logic                                saturated
);
	import pidaw_pkg::*;

	localparam int unsigned PD_W  = PROD_W + 1;
	localparam int unsigned SUM_W = INT_W + 1;
	localparam int unsigned SH_W  = SUM_W - EFFORT_SHIFT;

	localparam logic signed [SH_W-1:0] LIM_HI = SH_W'(DRIVE_LIMIT);
	localparam logic signed [SH_W-1:0] LIM_LO = -SH_W'(DRIVE_LIMIT);
	localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

	// gain registers
	gains_t gains_q [NUM_REGS];

	// integral RAM and per-entry valid bits
	logic [INT_W-1:0] int_mem [AXES];
	logic [AXES-1:0]  int_ok_q;

	// stage 1: registered request
	logic                     valid_s1;
	logic [AXIS_W-1:0]        axis_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [ERR_W-1:0]  nrate_s1;
	logic signed [DATA_W-1:0] manual_s1;
	logic                     enable_s1;
	gains_t                   gains_s1;

	// stage 2: products and integral read
	logic                     valid_s2;
	logic [AXIS_W-1:0]        axis_s2;
	logic signed [PROD_W-1:0] p_s2;
	logic signed [PROD_W-1:0] inc_s2;
	logic signed [PROD_W-1:0] d_s2;
	logic signed [DATA_W-1:0] manual_s2;
	logic                     enable_s2;
	logic signed [INT_W-1:0]  rd_s2;
	logic                     rd_ok_s2;
	logic                     fwd_s2;
	logic signed [INT_W-1:0]  fwd_val_s2;

	// result register
	logic                     out_valid_q;
	logic [AXIS_W-1:0]        axis_out_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     sat_q;

	logic                     adv;
	logic signed [INT_W-1:0]  old_int;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [INT_W-1:0]  new_int;
	logic signed [PD_W-1:0]   pd_sum;
	logic signed [SUM_W-1:0]  effort;
	logic signed [SH_W-1:0]   effort_sh;
	logic                     clamp;
	logic signed [DATA_W-1:0] drive_d;
	logic signed [INT_W-1:0]  wr_val;

	// whole pipeline moves unless the result register is held
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// gain register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) gains_q[i] <= '0;
		end else if (cfg_we) begin
			gains_q[cfg_index] <= gains_t'(cfg_data);
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload: error, negated rate, gains for this axis
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			axis_s1   <= axis;
			err_s1    <= ERR_W'(setpoint) - ERR_W'(measured);
			nrate_s1  <= -ERR_W'(rate);
			manual_s1 <= manual_drive;
			enable_s1 <= enable;
			gains_s1  <= gains_q[axis];
		end
	end

	// stage 2 control and forward flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			fwd_s2   <= 1'b0;
			rd_ok_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			// item ahead writes the entry this one reads in the same cycle
			fwd_s2   <= valid_s1 && valid_s2 && (axis_s1 == axis_s2);
			rd_ok_s2 <= int_ok_q[axis_s1];
		end
	end

	// stage 2 payload: three products, integral read
	always_ff @(posedge clk) begin
		if (adv) begin
			axis_s2    <= axis_s1;
			p_s2       <= PROD_W'(gains_s1.kp * err_s1);
			inc_s2     <= PROD_W'(gains_s1.ki * err_s1);
			d_s2       <= PROD_W'(gains_s1.kd * nrate_s1);
			manual_s2  <= manual_s1;
			enable_s2  <= enable_s1;
			rd_s2      <= int_mem[axis_s1];
			fwd_val_s2 <= wr_val;
		end
	end

	// integral update, effort sum and clamp
	always_comb begin
		if (fwd_s2) begin
			old_int = fwd_val_s2;
		end else if (rd_ok_s2) begin
			old_int = rd_s2;
		end else begin
			old_int = '0;
		end
		acc_sum = SUM_W'(old_int) + SUM_W'(inc_s2);
		// saturate at the integral width
		if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]) begin
			new_int = acc_sum[SUM_W-1] ? INT_MIN : INT_MAX;
		end else begin
			new_int = acc_sum[INT_W-1:0];
		end
		pd_sum    = PD_W'(p_s2) + PD_W'(d_s2);
		effort    = SUM_W'(new_int) + SUM_W'(pd_sum);
		effort_sh = SH_W'(effort >>> EFFORT_SHIFT);
		clamp     = 1'b0;
		drive_d   = manual_s2;
		wr_val    = INT_W'(inc_s2);
		if (enable_s2) begin
			priority if (effort_sh > LIM_HI) begin
				drive_d = DATA_W'(LIM_HI);
				clamp   = 1'b1;
			end else if (effort_sh < LIM_LO) begin
				drive_d = DATA_W'(LIM_LO);
				clamp   = 1'b1;
			end else begin
				drive_d = effort_sh[DATA_W-1:0];
			end
			// on a clamp the step is taken back
			wr_val = clamp ? old_int : new_int;
		end
	end

	// integral write-back
	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			int_mem[axis_s2] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_ok_q <= '0;
		end else if (adv && valid_s2) begin
			int_ok_q[axis_s2] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			axis_out_q <= axis_s2;
			drive_q    <= drive_d;
			sat_q      <= clamp;
		end
	end

	assign out_valid = out_valid_q;
	assign axis_out  = axis_out_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

FILE: rtl/pidaw_checker.sv
module pidaw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [pidaw_pkg::AXIS_W-1:0]        axis_out,
	input logic signed [pidaw_pkg::DATA_W-1:0] drive,
	input logic                                saturated
);
	import pidaw_pkg::*;

	localparam logic signed [DATA_W-1:0] LIM_P = DATA_W'(DRIVE_LIMIT);
	localparam logic signed [DATA_W-1:0] LIM_N = -DATA_W'(DRIVE_LIMIT);

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result does not change
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(axis_out) && $stable(drive) && $stable(saturated))
		else $error("stalled result changed");

	// a clamped result sits exactly on the limit
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (drive == LIM_P) || (drive == LIM_N))
		else $error("saturated flag without clamp value");

	// requests are only held back by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without back-pressure");

	// an accepted request that is never stalled on its way is offered as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall [*2] |=> out_valid)
		else $error("result missing after request");

endmodule

bind pid_axis_antiwindup_top pidaw_checker u_pidaw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.axis_out  (axis_out),
	.drive     (drive),
	.saturated (saturated)
);

FILE: test/tb_top.sv
module tb_top;
	import pidaw_pkg::*;

	// Axis codes
	localparam logic [AXIS_W-1:0] AX_THRUST = AXIS_W'(0);
	localparam logic [AXIS_W-1:0] AX_ROLL   = AXIS_W'(1);
	localparam logic [AXIS_W-1:0] AX_PITCH  = AXIS_W'(2);
	localparam logic [AXIS_W-1:0] AX_YAW    = AXIS_W'(3);

	localparam int DIR_N          = 24;
	localparam int ZERO_GAIN_ROWS = 4;
	localparam int PHASES         = 7;
	localparam int PHASE_REQS     = 250;

	typedef enum int {GM_SMALL, GM_FULL, GM_MAX, GM_MIN} gain_mode_e;

	typedef struct packed {
		logic [AXIS_W-1:0]        axis;
		logic signed [DATA_W-1:0] sp;
		logic signed [DATA_W-1:0] meas;
		logic signed [DATA_W-1:0] rate;
		logic signed [DATA_W-1:0] man;
		logic                     en;
	} req_t;

	typedef struct packed {
		logic [AXIS_W-1:0]        axis;
		logic signed [DATA_W-1:0] drive;
		logic                     sat;
	} result_t;

	typedef struct packed {
		req_t    r;
		logic    typed;
		result_t res;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IW-1:0]        cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [AXIS_W-1:0]        axis;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] measured;
	logic signed [DATA_W-1:0] rate;
	logic signed [DATA_W-1:0] manual_drive;
	logic                     enable;
	logic                     out_valid;
	logic                     out_stall;
	logic [AXIS_W-1:0]        axis_out;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;

	pid_axis_antiwindup_top DUT (.*);

	always #5 clk = ~clk;

	// Predictor state: gains per axis and Q.20 integrals
	gains_t  gain_reg [NUM_REGS];
	longint  integ_q20 [AXES];
	result_t drive_q [$];

	int errs         = 0;
	int results_seen = 0;
	int clamps_seen  = 0;
	int manual_reqs  = 0;
	bit in_quiet     = 1'b0;
	bit out_quiet    = 1'b0;

	// Directed requests; typed results only where obvious
	dir_row_t dir_tbl [DIR_N] = '{
		// zero gains after reset
		'{'{AX_THRUST, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, 16'sh0000, 1'b0}},
		'{'{AX_ROLL, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 1'b0}, 1'b1,
			'{AX_ROLL, 16'sh8000, 1'b0}},
		'{'{AX_PITCH, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0}, 1'b1,
			'{AX_PITCH, 16'sh7FFF, 1'b0}},
		'{'{AX_YAW, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1}, 1'b1,
			'{AX_YAW, 16'sh0000, 1'b0}},
		// extreme gains: clamps both ways, step taken back
		'{'{AX_THRUST, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, 16'sh4000, 1'b1}},
		'{'{AX_THRUST, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, -16'sh4000, 1'b1}},
		'{'{AX_ROLL, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_ROLL, -16'sh4000, 1'b1}},
		'{'{AX_THRUST, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, -16'sh4000, 1'b1}},
		// manual tick reloads the integral, next closed-loop tick clamps on it
		'{'{AX_THRUST, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh04D2, 1'b0}, 1'b1,
			'{AX_THRUST, 16'sh04D2, 1'b0}},
		'{'{AX_THRUST, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, 16'sh4000, 1'b1}},
		// unit Kp: exactly at the limit and one past it
		'{'{AX_PITCH, 16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_PITCH, 16'sh4000, 1'b0}},
		'{'{AX_PITCH, 16'sh1001, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_PITCH, 16'sh4000, 1'b1}},
		'{'{AX_PITCH, -16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_PITCH, -16'sh4000, 1'b0}},
		'{'{AX_PITCH, -16'sh1001, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_PITCH, -16'sh4000, 1'b1}},
		// floor of small negative effort
		'{'{AX_YAW, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_YAW, -16'sh0001, 1'b0}},
		'{'{AX_YAW, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_YAW, -16'sh0001, 1'b0}},
		'{'{AX_YAW, 16'sh0000, 16'sh0001, 16'sh0064, 16'sh0000, 1'b1}, 1'b0, '0},
		// manual passes through unclamped
		'{'{AX_ROLL, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000, 1'b0}, 1'b1,
			'{AX_ROLL, 16'sh8000, 1'b0}},
		'{'{AX_ROLL, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_ROLL, 16'sh4000, 1'b1}},
		'{'{AX_THRUST, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0}, 1'b1,
			'{AX_THRUST, 16'sh0000, 1'b0}},
		'{'{AX_THRUST, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b1,
			'{AX_THRUST, 16'sh0000, 1'b0}},
		'{'{AX_PITCH, 16'sh0064, -16'sh00C8, 16'sh012C, 16'sh0000, 1'b1}, 1'b0, '0},
		'{'{AX_YAW, 16'sh0005, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0}, 1'b1,
			'{AX_YAW, 16'sh7FFF, 1'b0}},
		'{'{AX_YAW, 16'sh0005, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1}, 1'b0, '0}
	};

	// Saturate to the signed integral width
	function automatic longint clip_integral(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (INT_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// One controller tick; updates the axis integral
	function automatic result_t pid_tick(req_t r);
		gains_t  g;
		longint  kp, ki, kd, err, inc, old_i, new_i, sum, d;
		result_t res;
		g     = gain_reg[r.axis];
		kp    = longint'(g.kp);
		ki    = longint'(g.ki);
		kd    = longint'(g.kd);
		err   = longint'(r.sp) - longint'(r.meas);
		inc   = ki * err;
		old_i = integ_q20[r.axis];
		res.axis = r.axis;
		res.sat  = 1'b0;
		if (!r.en) begin
			integ_q20[r.axis] = clip_integral(inc);
			res.drive = r.man;
		end else begin
			// sums stay far inside 64 bits at these widths
			new_i = clip_integral(old_i + inc);
			sum   = new_i + kp * err - kd * longint'(r.rate);
			d     = sum >>> EFFORT_SHIFT;
			if (d > DRIVE_LIMIT) begin
				d = DRIVE_LIMIT;
				res.sat = 1'b1;
			end else if (d < -DRIVE_LIMIT) begin
				d = -DRIVE_LIMIT;
				res.sat = 1'b1;
			end
			integ_q20[r.axis] = res.sat ? old_i : new_i;
			res.drive = d[DATA_W-1:0];
		end
		return res;
	endfunction

	// Random field value with random magnitude
	function automatic logic signed [DATA_W-1:0] rand_val();
		logic signed [DATA_W-1:0] v;
		v = DATA_W'($urandom);
		return v >>> $urandom_range(0, DATA_W - 1);
	endfunction

	function automatic req_t rand_req(logic [AXIS_W-1:0] last_axis);
		req_t r;
		r.axis = ($urandom_range(0, 1) != 0) ? last_axis : AXIS_W'($urandom_range(0, AXES - 1));
		r.sp   = rand_val();
		r.meas = rand_val();
		r.rate = rand_val();
		r.man  = rand_val();
		r.en   = ($urandom_range(0, 7) != 0);
		return r;
	endfunction

	function automatic gains_t rand_gains(gain_mode_e gm);
		gains_t g;
		case (gm)
			GM_SMALL: begin
				g.kp = $signed(GAIN_W'($urandom)) >>> $urandom_range(5, 13);
				g.ki = $signed(GAIN_W'($urandom)) >>> $urandom_range(5, 13);
				g.kd = $signed(GAIN_W'($urandom)) >>> $urandom_range(5, 13);
			end
			GM_FULL: g = CFG_W'({$urandom, $urandom});
			GM_MAX:  g = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
			default: g = '{16'sh8000, 16'sh8000, 16'sh8000};
		endcase
		return g;
	endfunction

	task automatic write_reg(logic [CFG_IW-1:0] idx, gains_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		gain_reg[idx] = val;
		@(negedge clk);
	endtask

	// Gains change only with the pipeline empty
	task automatic load_gains(gains_t t, gains_t r, gains_t p, gains_t y);
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_GAINS_THRUST, t);
		write_reg(REG_GAINS_ROLL, r);
		write_reg(REG_GAINS_PITCH, p);
		write_reg(REG_GAINS_YAW, y);
		cfg_we <= 1'b0;
	endtask

	// Drive one request; called and returns at a falling edge
	task automatic send_req(req_t r, bit typed, result_t typed_res);
		int      gap;
		result_t res;
		gap = in_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		axis         <= r.axis;
		setpoint     <= r.sp;
		measured     <= r.meas;
		rate         <= r.rate;
		manual_drive <= r.man;
		enable       <= r.en;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		res = pid_tick(r);
		drive_q.push_back(typed ? typed_res : res);
		if (!r.en) manual_reqs++;
		@(negedge clk);
	endtask

	// Result side: random stall, then check against the oldest pending result
	initial begin
		int      n;
		result_t want;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = out_quiet ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_seen++;
			if (saturated) clamps_seen++;
			if (drive_q.size() == 0) begin
				if (errs < 10)
					$display("ERROR: result axis=%0d drive=%0d sat=%0b with nothing pending",
						axis_out, drive, saturated);
				errs++;
			end else begin
				want = drive_q.pop_front();
				if (axis_out !== want.axis || drive !== want.drive || saturated !== want.sat) begin
					if (errs < 10)
						$display("ERROR: exp axis=%0d drive=%0d sat=%0b, got axis=%0d drive=%0d sat=%0b",
							want.axis, want.drive, want.sat, axis_out, drive, saturated);
					errs++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		req_t          r;
		logic [AXIS_W-1:0] last_axis;
		gain_mode_e    gm;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		axis         = '0;
		setpoint     = '0;
		measured     = '0;
		rate         = '0;
		manual_drive = '0;
		enable       = 1'b0;
		arst_n       = 1'b0;
		foreach (gain_reg[i]) gain_reg[i] = '0;
		foreach (integ_q20[i]) integ_q20[i] = 0;
		last_axis = AX_THRUST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		for (int i = 0; i < DIR_N; i++) begin
			if (i == ZERO_GAIN_ROWS)
				load_gains('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '{16'sh8000, 16'sh8000, 16'sh8000},
					'{16'sh0000, 16'sh0000, 16'sh0100}, '{16'sh0100, 16'sh0001, 16'sh0000});
			send_req(dir_tbl[i].r, dir_tbl[i].typed, dir_tbl[i].res);
		end

		// random phases, each with its own gain setting
		for (int ph = 0; ph < PHASES; ph++) begin
			gm = (ph == 2) ? GM_MAX : (ph == 4) ? GM_MIN : (ph % 2 == 1) ? GM_FULL : GM_SMALL;
			load_gains(rand_gains(gm), rand_gains(gm), rand_gains(gm), rand_gains(gm));
			for (int k = 0; k < PHASE_REQS; k++) begin
				if (k % 40 == 0) begin
					in_quiet  = ($urandom_range(0, 3) == 0);
					out_quiet = ($urandom_range(0, 3) == 0);
				end
				r = rand_req(last_axis);
				last_axis = r.axis;
				send_req(r, 1'b0, '0);
			end
		end

		// drain, then watch for stray results
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("Checked %0d results (%0d clamped, %0d manual ticks) over %0d gain settings",
			results_seen, clamps_seen, manual_reqs, PHASES + 2);
		if (errs == 0 && drive_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errs);
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Timeout with %0d results pending", drive_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pidaw_pkg.sv
rtl/pid_axis_antiwindup_top.sv
rtl/pidaw_checker.sv
test/tb_top.sv
